[rtl/gfla_pkg.sv]
`default_nettype none

package gfla_pkg;

   // payload and register widths
   localparam int MODE_W   = 2;
   localparam int HANDLE_W = 8;
   localparam int SIZE_W   = 9;
   localparam int CSR_W    = 2;

   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [HANDLE_W-1:0] handle_type;
   typedef logic [SIZE_W-1:0]   size_type;
   typedef logic [CSR_W-1:0]    csr_index_type;

   // request modes
   localparam mode_type MODE_ALLOC = 2'd0;
   localparam mode_type MODE_FREE  = 2'd1;
   localparam mode_type MODE_INIT  = 2'd2;

   // register indexes
   localparam csr_index_type CSR_INITIAL_SIZE = 2'd0;
   localparam csr_index_type CSR_MAX_SIZE     = 2'd1;
   localparam csr_index_type CSR_EXPANSION    = 2'd2;

   // register reset values
   localparam size_type RST_INITIAL_SIZE = 9'd64;
   localparam size_type RST_MAX_SIZE     = 9'd256;
   localparam size_type RST_EXPANSION    = 9'd32;

endpackage

`default_nettype wire

[rtl/gfla_ram.sv]
`default_nettype none

module gfla_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 256
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic                                   re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

[rtl/growable_free_list_allocator_top.sv]
`default_nettype none

// Handle allocator over a singly linked free list kept in one link memory
// (MAX_ENTRIES words, one read and one write port, registered read). The
// head of the list and the link stored at the head are held in registers,
// so a free needs no memory read and an allocate reads one link: the
// accept cycle reads the link of the next free handle out of the memory and
// the following cycle retires the pop. When an allocate leaves one handle or
// none free and the pool is below max_size, the pool grows by
// expansion_increment (clamped to max_size and to MAX_ENTRIES); the new
// handles are chained one memory write per cycle, and a reinitialize links
// its handles the same way. After reset the block links its first
// min(64, MAX_ENTRIES) handles before the first request beat is taken;
// register writes are taken at any time. The response of every request
// sits in an output register; a new request is taken when the engine is
// idle and that register is empty or being drained in the same cycle.
module growable_free_list_allocator_top #(
   parameter int MAX_ENTRIES = 256
) (
   input  wire logic                    clock,
   input  wire logic                    reset,

   // request channel
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire gfla_pkg::mode_type      req_mode,
   input  wire gfla_pkg::handle_type    req_handle,

   // response channel
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output gfla_pkg::handle_type         rsp_result_handle,
   output logic                         rsp_ok,
   output gfla_pkg::size_type           rsp_pool_size,

   // register write channel
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire gfla_pkg::csr_index_type csr_index,
   input  wire gfla_pkg::size_type      csr_data
);

   import gfla_pkg::*;

   // memory address and link widths; the null link is MAX_ENTRIES itself
   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int LW = $clog2(MAX_ENTRIES + 1);
   localparam logic [LW-1:0] NULL_LINK = LW'(MAX_ENTRIES);

   // a pool can never exceed either the memory or the size field
   localparam int SIZE_CAP_I = (MAX_ENTRIES > 511) ? 511 : MAX_ENTRIES;
   localparam size_type SIZE_CAP = SIZE_W'(SIZE_CAP_I);

   // pool built at reset: min(64, MAX_ENTRIES) handles
   localparam int RST_SIZE_I = (MAX_ENTRIES > 64) ? 64 : MAX_ENTRIES;
   localparam size_type RST_SIZE = SIZE_W'(RST_SIZE_I);
   localparam logic [LW-1:0] RST_HEAD_NEXT = (RST_SIZE_I > 1) ? LW'(1) : NULL_LINK;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ALLOC,
      S_CHAIN
   } state_type;

   state_type  state_ff, state_in;

   // list state
   logic [LW-1:0] head_ff, head_in;            // first free handle
   logic [LW-1:0] head_next_ff, head_next_in;  // copy of the link stored at head
   size_type      size_ff, size_in;

   // chain sweep: links cnt..end-1 in ascending order
   size_type      cnt_ff, cnt_in;
   size_type      end_ff, end_in;

   // registers
   size_type      initial_size_ff, initial_size_in;
   size_type      max_size_ff, max_size_in;
   size_type      expansion_ff, expansion_in;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   handle_type    rsp_handle_ff, rsp_handle_in;
   logic          rsp_ok_ff, rsp_ok_in;
   size_type      rsp_size_ff, rsp_size_in;

   // link memory port
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [LW-1:0] mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic [LW-1:0] mem_rdata;

   // working values
   size_type      eff_max;
   size_type      init_size;
   logic          out_free;
   logic          req_beat;
   logic          pop_ok;
   logic [LW-1:0] new_head;
   logic [LW-1:0] new_next;
   logic          few_left;
   logic          grow;
   logic [SIZE_W:0] grown_sum;
   size_type      grown;
   logic [SIZE_W:0] size_plus1;
   logic [SIZE_W:0] cnt_plus1;

   gfla_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_ENTRIES)
   ) u_link_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign csr_ready = 1'b1;

   // output register is free when empty or drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign req_beat  = req_valid && req_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_handle = rsp_handle_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_pool_size     = rsp_size_ff;

   // max_size and the increment are read live at every growth
   assign eff_max   = (max_size_ff < SIZE_CAP) ? max_size_ff : SIZE_CAP;
   assign init_size = (initial_size_ff < eff_max) ? initial_size_ff : eff_max;

   // pop evaluation, valid in S_ALLOC when the link read has returned
   assign pop_ok     = (head_ff != NULL_LINK);
   assign new_head   = pop_ok ? head_next_ff : NULL_LINK;
   assign new_next   = (new_head == NULL_LINK) ? NULL_LINK : mem_rdata;
   assign few_left   = (new_head == NULL_LINK) || (new_next == NULL_LINK);
   assign grow       = few_left && (size_ff < eff_max) && (expansion_ff != '0);
   assign grown_sum  = {1'b0, size_ff} + {1'b0, expansion_ff};
   assign grown      = (grown_sum > {1'b0, eff_max}) ? eff_max : grown_sum[SIZE_W-1:0];
   assign size_plus1 = {1'b0, size_ff} + 1'b1;
   assign cnt_plus1  = {1'b0, cnt_ff} + 1'b1;

   always_comb begin
      state_in        = state_ff;
      head_in         = head_ff;
      head_next_in    = head_next_ff;
      size_in         = size_ff;
      cnt_in          = cnt_ff;
      end_in          = end_ff;
      initial_size_in = initial_size_ff;
      max_size_in     = max_size_ff;
      expansion_in    = expansion_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_handle_in   = rsp_handle_ff;
      rsp_ok_in       = rsp_ok_ff;
      rsp_size_in     = rsp_size_ff;
      mem_we          = 1'b0;
      mem_waddr       = AW'(cnt_ff);
      mem_wdata       = NULL_LINK;
      mem_re          = 1'b0;
      mem_raddr       = AW'(head_next_ff);

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_INITIAL_SIZE: initial_size_in = csr_data;
            CSR_MAX_SIZE:     max_size_in     = csr_data;
            CSR_EXPANSION:    expansion_in    = csr_data;
            default: ;  // unused index, write dropped
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               case (req_mode)
                  MODE_ALLOC: begin
                     // fetch the link of the handle that becomes the head
                     mem_re   = (head_next_ff != NULL_LINK);
                     state_in = S_ALLOC;
                  end
                  MODE_FREE: begin
                     // size never exceeds the memory depth, so this bounds the index too
                     rsp_valid_in  = 1'b1;
                     rsp_handle_in = '0;
                     rsp_size_in   = size_ff;
                     rsp_ok_in     = ({1'b0, req_handle} < size_ff);
                     if ({1'b0, req_handle} < size_ff) begin
                        mem_we       = 1'b1;
                        mem_waddr    = AW'(req_handle);
                        mem_wdata    = head_ff;
                        head_in      = LW'(req_handle);
                        head_next_in = head_ff;
                     end
                  end
                  MODE_INIT: begin
                     size_in       = init_size;
                     head_in       = (init_size != '0) ? '0 : NULL_LINK;
                     head_next_in  = (init_size > 9'd1) ? LW'(1) : NULL_LINK;
                     cnt_in        = '0;
                     end_in        = init_size;
                     state_in      = (init_size != '0) ? S_CHAIN : S_IDLE;
                     rsp_valid_in  = 1'b1;
                     rsp_handle_in = '0;
                     rsp_ok_in     = 1'b1;
                     rsp_size_in   = init_size;
                  end
                  default: begin
                     // unused mode: refused, nothing changes
                     rsp_valid_in  = 1'b1;
                     rsp_handle_in = '0;
                     rsp_ok_in     = 1'b0;
                     rsp_size_in   = size_ff;
                  end
               endcase
            end
         end

         S_ALLOC: begin
            // output register was drained when this request was taken
            rsp_valid_in  = 1'b1;
            rsp_handle_in = pop_ok ? HANDLE_W'(head_ff) : '0;
            rsp_ok_in     = pop_ok;
            if (grow) begin
               size_in     = grown;
               rsp_size_in = grown;
               cnt_in      = size_ff;
               end_in      = grown;
               state_in    = S_CHAIN;
               if (new_head == NULL_LINK) begin
                  // list was empty: the new chain becomes the list
                  head_in      = LW'(size_ff);
                  head_next_in = (size_plus1 < {1'b0, grown}) ? LW'(size_plus1) : NULL_LINK;
               end else begin
                  // hang the new chain behind the one remaining free handle
                  mem_we       = 1'b1;
                  mem_waddr    = AW'(new_head);
                  mem_wdata    = LW'(size_ff);
                  head_in      = new_head;
                  head_next_in = LW'(size_ff);
               end
            end else begin
               head_in      = new_head;
               head_next_in = new_next;
               rsp_size_in  = size_ff;
               state_in     = S_IDLE;
            end
         end

         S_CHAIN: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(cnt_ff);
            mem_wdata = (cnt_plus1 < {1'b0, end_ff}) ? LW'(cnt_plus1) : NULL_LINK;
            cnt_in    = cnt_plus1[SIZE_W-1:0];
            if (cnt_plus1 >= {1'b0, end_ff}) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      state_ff        <= state_in;
      head_ff         <= head_in;
      head_next_ff    <= head_next_in;
      size_ff         <= size_in;
      cnt_ff          <= cnt_in;
      end_ff          <= end_in;
      initial_size_ff <= initial_size_in;
      max_size_ff     <= max_size_in;
      expansion_ff    <= expansion_in;
      rsp_valid_ff    <= rsp_valid_in;
      rsp_handle_ff   <= rsp_handle_in;
      rsp_ok_ff       <= rsp_ok_in;
      rsp_size_ff     <= rsp_size_in;
      if (reset) begin
         // link the reset pool before taking requests
         state_ff        <= S_CHAIN;
         head_ff         <= '0;
         head_next_ff    <= RST_HEAD_NEXT;
         size_ff         <= RST_SIZE;
         cnt_ff          <= '0;
         end_ff          <= RST_SIZE;
         initial_size_ff <= RST_INITIAL_SIZE;
         max_size_ff     <= RST_MAX_SIZE;
         expansion_ff    <= RST_EXPANSION;
         rsp_valid_ff    <= 1'b0;
      end
   end

endmodule

`default_nettype wire

[rtl/gfla_checker.sv]
`default_nettype none

module gfla_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire gfla_pkg::handle_type rsp_result_handle,
   input wire logic                 rsp_ok,
   input wire gfla_pkg::size_type   rsp_pool_size
);

   import gfla_pkg::*;

   logic req_beat;
   assign req_beat = req_valid && req_ready;

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_handle)
         && $stable(rsp_ok) && $stable(rsp_pool_size))
      else $error("response beat changed while stalled");

   // a nonzero handle only comes from a successful allocate inside the pool
   a_handle_in_pool: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_handle != '0) |->
         rsp_ok && ({1'b0, rsp_result_handle} < rsp_pool_size))
      else $error("handle returned outside the pool");

   // a refused request never carries a handle
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> (rsp_result_handle == '0))
      else $error("refused response carries a handle");

   // every new response follows an earlier request beat
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_beat, 1) || $past(req_beat, 2))
      else $error("response without a request");

endmodule

bind growable_free_list_allocator_top gfla_checker u_gfla_checker (.*);

`default_nettype wire
